[rtl/mlqs_pkg.sv]
package mlqs_pkg;

  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned GLVL_W  = 5;
  localparam int unsigned TOTAL_W = 10;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_FIN
  } st_e;

endpackage

[rtl/mlqs_intf.sv]
interface mlqs_in_if import mlqs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  op_e                      func;
  logic signed [PRIO_W-1:0] priority_req;
  logic [ID_W-1:0]          process_id;

  modport source (output valid, func, priority_req, process_id, input ready);
  modport sink (input valid, func, priority_req, process_id, output ready);
endinterface

interface mlqs_out_if import mlqs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [ID_W-1:0]    granted_id;
  logic [GLVL_W-1:0]  granted_level;
  logic               dropped;
  logic [TOTAL_W-1:0] ready_total;

  modport source (output valid, granted, granted_id, granted_level, dropped, ready_total,
                  input ready);
  modport sink (input valid, granted, granted_id, granted_level, dropped, ready_total,
                output ready);
endinterface

[rtl/mlqs_ram.sv]
module mlqs_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mlqs_level_pick.sv]
module mlqs_level_pick #(
  parameter int unsigned LEVELS = 32
) (
  input  logic [LEVELS-1:0]         req_i,
  output logic                      found_o,
  output logic [$clog2(LEVELS)-1:0] idx_o
);

  localparam int unsigned LW = $clog2(LEVELS);

  logic [LEVELS-1:0] lowest;
  logic [LW-1:0]     idx;

  // isolate lowest set bit, then encode the one-hot word
  assign lowest = req_i & (~req_i + LEVELS'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (lowest[i]) begin
        idx = idx | LW'(i);
      end
    end
  end

  assign found_o = |req_i;
  assign idx_o   = idx;

endmodule

[rtl/multilevel_queue_slot_scheduler.sv]
// Multilevel ready-queue scheduler: one FIFO of process ids per priority level, with a per-level
// slot budget that refills to LEVELS minus the level once no level holding work has budget left.
// Each transfer on in_i yields exactly one transfer on out_o. An accepted item moves through ST_RD
// to ST_FIN, where it is loaded into the result register once out_o is free; a new item is only
// accepted in ST_IDLE or alongside that load. This pacing comes from the level-table round trip:
// the level record is read in the accept cycle and written back the next cycle, when the id memory
// is also accessed. Per-level occupancy and budget flags sit in flip-flops, so reset needs no
// clearing pass and the block is ready right after reset.
module multilevel_queue_slot_scheduler import mlqs_pkg::*; #(
  parameter int unsigned LEVELS      = 32,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  mlqs_in_if.sink  in_i,
  mlqs_out_if.source out_o
);

  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned BW = $clog2(LEVELS + 1);
  localparam int unsigned TW = $clog2(LEVELS * QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [BW-1:0] budget;
  } lrec_t;

  st_e               state_q, state_d;
  op_e               op_q;
  logic [LW-1:0]     lv_q, lv_d, lv_clamp, pick_idx;
  logic [ID_W-1:0]   pid_q;
  logic              hit_q;
  logic [LEVELS-1:0] nonempty_q, budget_ok_q, rec_valid_q, fresh_q;
  logic [TW-1:0]     total_q;
  logic              res_granted_q, res_dropped_q;

  logic               out_valid_q, granted_q, dropped_q;
  logic [ID_W-1:0]    gid_q;
  logic [GLVL_W-1:0]  glvl_q;
  logic [TOTAL_W-1:0] total_out_q;

  logic              in_accept, in_rdy, out_free, out_load;
  logic [LEVELS-1:0] elig, pick_req;
  logic              pick_found, refill;
  logic [PRIO_W:0]   prio_ext;
  lrec_t             rec_rd, rec, rec_wr;
  logic [PW-1:0]     head_nx, tail_nx;
  logic [BW-1:0]     budget_nx;
  logic              full, enq_ok, deq_ok, rd_phase;
  logic [ID_W-1:0]   id_rdata;
  logic [LW+GLVL_W-1:0]  glvl_ext;
  logic [TW+TOTAL_W-1:0] total_ext;

  // ---------------------------------------------------------------- accept side
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_accept = in_i.valid && in_rdy;
  assign in_i.ready = in_rdy;

  assign elig     = nonempty_q & budget_ok_q;
  assign pick_req = (|elig) ? elig : nonempty_q;
  assign refill   = in_accept && (in_i.func == OP_DEQ) && (total_q != '0) && !(|elig);

  mlqs_level_pick #(.LEVELS(LEVELS)) u_pick (
    .req_i   (pick_req),
    .found_o (pick_found),
    .idx_o   (pick_idx)
  );

  assign prio_ext = {1'b0, in_i.priority_req};

  always_comb begin
    if (in_i.priority_req[PRIO_W-1]) begin
      lv_clamp = '0;
    end else if (prio_ext >= (PRIO_W+1)'(LEVELS)) begin
      lv_clamp = LW'(LEVELS - 1);
    end else begin
      lv_clamp = LW'(prio_ext);
    end
  end

  assign lv_d = (in_i.func == OP_DEQ) ? pick_idx : lv_clamp;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= in_i.func;
      lv_q  <= lv_d;
      pid_q <= in_i.process_id;
      hit_q <= pick_found;
    end
  end

  // ---------------------------------------------------------------- level table
  mlqs_ram #(.W($bits(lrec_t)), .DEPTH(LEVELS)) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (rd_phase && (enq_ok || deq_ok)),
    .waddr_i (lv_q),
    .wdata_i (rec_wr),
    .re_i    (in_accept),
    .raddr_i (lv_d),
    .rdata_o (rec_rd)
  );

  assign rd_phase = (state_q == ST_RD);

  always_comb begin
    rec = rec_rd;
    if (!rec_valid_q[lv_q]) begin
      rec.head = '0;
      rec.tail = '0;
    end
    if (fresh_q[lv_q]) begin
      rec.budget = BW'(LEVELS) - BW'(lv_q);
    end
  end

  assign head_nx   = (rec.head == PW'(QUEUE_DEPTH - 1)) ? '0 : rec.head + PW'(1);
  assign tail_nx   = (rec.tail == PW'(QUEUE_DEPTH - 1)) ? '0 : rec.tail + PW'(1);
  assign budget_nx = rec.budget - BW'(1);

  assign full   = nonempty_q[lv_q] && (rec.head == rec.tail);
  assign enq_ok = (op_q == OP_ENQ) && !full;
  assign deq_ok = (op_q == OP_DEQ) && hit_q;

  always_comb begin
    rec_wr = rec;
    if (op_q == OP_ENQ) begin
      rec_wr.tail = tail_nx;
    end else begin
      rec_wr.head   = head_nx;
      rec_wr.budget = budget_nx;
    end
  end

  // ---------------------------------------------------------------- id store
  mlqs_ram #(.W(ID_W), .DEPTH(LEVELS << PW)) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (rd_phase && enq_ok),
    .waddr_i ({lv_q, rec.tail}),
    .wdata_i (pid_q),
    .re_i    (rd_phase && deq_ok),
    .raddr_i ({lv_q, rec.head}),
    .rdata_o (id_rdata)
  );

  // ---------------------------------------------------------------- flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q  <= '0;
      budget_ok_q <= '1;
      rec_valid_q <= '0;
      fresh_q     <= '1;
      total_q     <= '0;
    end else begin
      if (refill) begin
        fresh_q     <= '1;
        budget_ok_q <= '1;
      end
      if (rd_phase && enq_ok) begin
        nonempty_q[lv_q]  <= 1'b1;
        rec_valid_q[lv_q] <= 1'b1;
        total_q           <= total_q + TW'(1);
      end
      if (rd_phase && deq_ok) begin
        nonempty_q[lv_q]  <= (head_nx != rec.tail);
        budget_ok_q[lv_q] <= (budget_nx != '0);
        fresh_q[lv_q]     <= 1'b0;
        rec_valid_q[lv_q] <= 1'b1;
        total_q           <= total_q - TW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_phase) begin
      res_granted_q <= deq_ok;
      res_dropped_q <= (op_q == OP_ENQ) && full;
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = in_accept ? ST_RD : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_rdy   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_rdy = 1'b1;
      end
      ST_FIN: begin
        in_rdy   = out_free;
        out_load = out_free;
      end
      default: begin
        in_rdy   = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- result register
  assign glvl_ext  = {{GLVL_W{1'b0}}, lv_q};
  assign total_ext = {{TOTAL_W{1'b0}}, total_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      granted_q   <= res_granted_q;
      gid_q       <= res_granted_q ? id_rdata : '0;
      glvl_q      <= res_granted_q ? glvl_ext[GLVL_W-1:0] : '0;
      dropped_q   <= res_dropped_q;
      total_out_q <= total_ext[TOTAL_W-1:0];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.granted       = granted_q;
  assign out_o.granted_id    = gid_q;
  assign out_o.granted_level = glvl_q;
  assign out_o.dropped       = dropped_q;
  assign out_o.ready_total   = total_out_q;

  // ---------------------------------------------------------------- checks
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(LEVELS * QUEUE_DEPTH))
    else $error("queued total out of range");

  a_total_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != '0) == (|nonempty_q))
    else $error("queued total disagrees with level flags");

  a_accept_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_RD))
    else $error("accepted item did not start table update");

  a_grant_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(granted_q && dropped_q))
    else $error("result both granted and dropped");

endmodule
